// File: sv/torq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package torq_pkg;

  // request modes
  localparam logic [2:0] M_INSERT   = 3'd0;
  localparam logic [2:0] M_REM_HEAD = 3'd1;
  localparam logic [2:0] M_REM_AT   = 3'd2;
  localparam logic [2:0] M_FIND     = 3'd3;
  localparam logic [2:0] M_GET      = 3'd4;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_BADPOS   = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic [31:0]        ts;
    logic [7:0]         src;
    logic signed [31:0] data;
  } torq_slot_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [3:0]         found_position;
    logic [7:0]         out_src;
    logic signed [31:0] out_data;
    logic [4:0]         occupancy;
  } torq_res_t;

endpackage

`default_nettype wire

// File: sv/torq_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface torq_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic [31:0]        entry_ts;
  logic [7:0]         entry_src;
  logic signed [31:0] entry_data;
  logic [3:0]         position;

  modport source (
    output valid, mode, entry_ts, entry_src, entry_data, position,
    input  ready
  );

  modport sink (
    input  valid, mode, entry_ts, entry_src, entry_data, position,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/torq_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface torq_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [3:0]         found_position;
  logic [7:0]         out_src;
  logic signed [31:0] out_data;
  logic [4:0]         occupancy;

  modport source (
    output valid, status, found_position, out_src, out_data, occupancy,
    input  ready
  );

  modport sink (
    input  valid, status, found_position, out_src, out_data, occupancy,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/torq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module torq_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: sv/torq_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module torq_seq #(
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  torq_req_if.sink                      req_i,
  output logic                          res_valid_o,
  output torq_pkg::torq_res_t           res_o,
  input  wire logic                     res_ready_i,
  output logic                          wr_en_o,
  output logic [$clog2(DEPTH)-1:0]      wr_addr_o,
  output torq_pkg::torq_slot_t          wr_data_o,
  output logic                          rd_en_o,
  output logic [$clog2(DEPTH)-1:0]      rd_addr_o,
  input  wire torq_pkg::torq_slot_t     rd_data_i
);

  import torq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 4) ? CW : 4;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_PUT  = 3'd2;
  localparam logic [2:0] S_REM  = 3'd3;
  localparam logic [2:0] S_FIND = 3'd4;
  localparam logic [2:0] S_GET  = 3'd5;
  localparam logic [2:0] S_RESP = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [AW-1:0]      idx_q, idx_d;
  torq_slot_t         key_q, key_d;
  logic [2:0]         status_q, status_d;
  logic [3:0]         fpos_q, fpos_d;
  logic [7:0]         osrc_q, osrc_d;
  logic signed [31:0] odata_q, odata_d;

  torq_slot_t    in_slot;
  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] last_a;
  logic [PW-1:0] pos_ext;
  logic [PW-1:0] cnt_ext;
  logic [AW-1:0] pos_a;
  logic [AW-1:0] rem_a;
  logic          pos_bad;
  logic          cnt_full;
  logic          idx_last;
  logic          slot_less;
  logic          slot_greater;
  logic          slot_equal;
  logic          moves;
  logic [31:0]   idx_w;
  logic [31:0]   cnt_w;

  assign in_slot  = '{ts: req_i.entry_ts, src: req_i.entry_src, data: req_i.entry_data};
  assign cnt_m1   = cnt_q - CW'(1);
  assign last_a   = AW'(cnt_m1);
  assign pos_ext  = PW'(req_i.position);
  assign cnt_ext  = PW'(cnt_q);
  assign pos_a    = pos_ext[AW-1:0];
  assign pos_bad  = pos_ext >= cnt_ext;
  assign rem_a    = (req_i.mode == M_REM_HEAD) ? '0 : pos_a;
  assign cnt_full = cnt_q == CW'(DEPTH);
  assign idx_last = CW'(idx_q) == cnt_m1;
  assign idx_w    = 32'(idx_q);
  assign cnt_w    = 32'(cnt_q);

  // ordering of the slot just read against the request key
  assign slot_equal   = (rd_data_i.ts == key_q.ts) && (rd_data_i.src == key_q.src);
  assign slot_less    = (rd_data_i.ts < key_q.ts) ||
                        ((rd_data_i.ts == key_q.ts) && (rd_data_i.src < key_q.src));
  assign slot_greater = !slot_less && !slot_equal;
  // an entry equal to the head goes behind it, elsewhere in front of its equals
  assign moves        = (idx_q != '0) ? !slot_less : slot_greater;

  assign req_i.ready  = state_q == S_IDLE;
  assign res_valid_o  = state_q == S_RESP;
  assign res_o = '{status: status_q, found_position: fpos_q, out_src: osrc_q,
                   out_data: odata_q, occupancy: cnt_w[4:0]};

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    key_d     = key_q;
    status_d  = status_q;
    fpos_d    = fpos_q;
    osrc_d    = osrc_q;
    odata_d   = odata_q;
    wr_en_o   = 1'b0;
    wr_addr_o = idx_q;
    wr_data_o = key_q;
    rd_en_o   = 1'b0;
    rd_addr_o = idx_q;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          key_d    = in_slot;
          status_d = ST_OK;
          fpos_d   = '0;
          osrc_d   = '0;
          odata_d  = '0;
          state_d  = S_RESP;
          case (req_i.mode)
            M_INSERT: begin
              if (cnt_full) begin
                status_d = ST_FULL;
              end else if (cnt_q == '0) begin
                wr_en_o   = 1'b1;
                wr_addr_o = '0;
                wr_data_o = in_slot;
                cnt_d     = cnt_q + CW'(1);
              end else begin
                // walk down from the tail, shifting entries up by one
                rd_en_o   = 1'b1;
                rd_addr_o = last_a;
                idx_d     = last_a;
                state_d   = S_INS;
              end
            end
            M_REM_HEAD, M_REM_AT: begin
              if (cnt_q == '0) begin
                status_d = ST_EMPTY;
              end else if ((req_i.mode == M_REM_AT) && pos_bad) begin
                status_d = ST_BADPOS;
              end else if (rem_a == last_a) begin
                cnt_d = cnt_m1;
              end else begin
                rd_en_o   = 1'b1;
                rd_addr_o = rem_a + AW'(1);
                idx_d     = rem_a + AW'(1);
                state_d   = S_REM;
              end
            end
            M_FIND: begin
              if (cnt_q == '0) begin
                status_d = ST_NOTFOUND;
              end else begin
                rd_en_o   = 1'b1;
                rd_addr_o = '0;
                idx_d     = '0;
                state_d   = S_FIND;
              end
            end
            M_GET: begin
              if (cnt_q == '0) begin
                status_d = ST_EMPTY;
              end else if (pos_bad) begin
                status_d = ST_BADPOS;
              end else begin
                rd_en_o   = 1'b1;
                rd_addr_o = pos_a;
                state_d   = S_GET;
              end
            end
            default: begin
              status_d = ST_OK;
            end
          endcase
        end
      end
      S_INS: begin
        wr_en_o   = 1'b1;
        wr_addr_o = idx_q + AW'(1);
        if (moves) begin
          wr_data_o = rd_data_i;
          if (idx_q == '0) begin
            state_d = S_PUT;
          end else begin
            rd_en_o   = 1'b1;
            rd_addr_o = idx_q - AW'(1);
            idx_d     = idx_q - AW'(1);
          end
        end else begin
          wr_data_o = key_q;
          cnt_d     = cnt_q + CW'(1);
          state_d   = S_RESP;
        end
      end
      S_PUT: begin
        wr_en_o   = 1'b1;
        wr_addr_o = '0;
        wr_data_o = key_q;
        cnt_d     = cnt_q + CW'(1);
        state_d   = S_RESP;
      end
      S_REM: begin
        wr_en_o   = 1'b1;
        wr_addr_o = idx_q - AW'(1);
        wr_data_o = rd_data_i;
        if (idx_last) begin
          cnt_d   = cnt_m1;
          state_d = S_RESP;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = idx_q + AW'(1);
          idx_d     = idx_q + AW'(1);
        end
      end
      S_FIND: begin
        if (slot_equal) begin
          fpos_d  = idx_w[3:0];
          state_d = S_RESP;
        end else if (idx_last) begin
          status_d = ST_NOTFOUND;
          state_d  = S_RESP;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = idx_q + AW'(1);
          idx_d     = idx_q + AW'(1);
        end
      end
      S_GET: begin
        osrc_d  = rd_data_i.src;
        odata_d = rd_data_i.data;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    key_q    <= key_d;
    status_q <= status_d;
    fpos_q   <= fpos_d;
    osrc_q   <= osrc_d;
    odata_q  <= odata_d;
  end

endmodule

`default_nettype wire

// File: sv/torq_out.sv
`timescale 1ns / 1ps
`default_nettype none

module torq_out (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire torq_pkg::torq_res_t in_res_i,
  output logic               in_ready_o,
  torq_rsp_if.source         rsp_o
);

  import torq_pkg::*;

  logic      valid_q, valid_d;
  torq_res_t res_q, res_d;

  assign in_ready_o = !valid_q || rsp_o.ready;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
      res_d   = in_res_i;
    end else if (rsp_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign rsp_o.valid          = valid_q;
  assign rsp_o.status         = res_q.status;
  assign rsp_o.found_position = res_q.found_position;
  assign rsp_o.out_src        = res_q.out_src;
  assign rsp_o.out_data       = res_q.out_data;
  assign rsp_o.occupancy      = res_q.occupancy;

endmodule

`default_nettype wire

// File: sv/timestamp_ordered_request_queue_top.sv
// how each request is served:
// refused requests, unused modes, insert into an empty queue: no slot read; get-nth: one slot read
// insert: walks the entries at or behind the insert point; remove: walks the entries behind it
// find: reads from the head up to the match, or every entry when nothing matches
// one request at a time (slot ram has one read and one write port); the next is taken once the sequencer is idle again
// reset clears the entry count and the handshakes; slot storage is left as is, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module timestamp_ordered_request_queue_top #(
  parameter int DEPTH = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  torq_req_if.sink   req_i,
  torq_rsp_if.source rsp_o
);

  import torq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int SW = $bits(torq_slot_t);

  logic          res_valid;
  logic          res_ready;
  torq_res_t     res;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  torq_slot_t    wr_slot;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  torq_slot_t    rd_slot;
  logic [SW-1:0] rd_word;
  logic [31:0]   depth_w;

  assign rd_slot = rd_word;
  assign depth_w = 32'(DEPTH);

  torq_seq #(
    .DEPTH(DEPTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_slot),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_slot)
  );

  torq_ram #(
    .WIDTH(SW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_slot),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_word)
  );

  torq_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (res_valid),
    .in_res_i   (res),
    .in_ready_o (res_ready),
    .rsp_o      (rsp_o)
  );

  // a sequencer that takes a request is not ready again in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request taken while sequencer busy");

  // a refused insert reports a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == ST_FULL) |-> (rsp_o.occupancy == depth_w[4:0]))
    else $error("full status with wrong occupancy");

  // empty status only with nothing stored
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == ST_EMPTY) |-> (rsp_o.occupancy == 5'd0))
    else $error("empty status with entries held");

  // ram is never read and written at the same entry in one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("slot ram read and write collide");

endmodule

`default_nettype wire
